FILE: rtl/gqi_pkg.sv
// package for the gyro quaternion integrator
// holds sequencer state type, seed table and fixed-point constants; no dependencies
package gqi_pkg;

  localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;
  localparam logic [32:0] THREE_Q30 = 33'd3221225472;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_DELTA = 8'b00000010,
    ST_PROD  = 8'b00000100,
    ST_NORM  = 8'b00001000,
    ST_SCALE = 8'b00010000,
    ST_NEWT  = 8'b00100000,
    ST_OUT   = 8'b01000000,
    ST_DONE  = 8'b10000000
  } gqi_state_t;

  function automatic logic [31:0] seed_lookup(input logic [3:0] idx);
    logic [31:0] v;
    case (idx)
      4'd0:  v = 32'd1012333456;
      4'd1:  v = 32'd915690249;
      4'd2:  v = 32'd842312880;
      4'd3:  v = 32'd784150433;
      4'd4:  v = 32'd736580449;
      4'd5:  v = 32'd696736038;
      4'd6:  v = 32'd662727413;
      4'd7:  v = 32'd633258568;
      4'd8:  v = 32'd607399644;
      4'd9:  v = 32'd584470961;
      4'd10: v = 32'd563957224;
      4'd11: v = 32'd545461920;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/gyro_quaternion_integrator.sv
// gyro quaternion integrator top level
// one shared 34x34 signed multiplier under a small sequencer; uses gqi_pkg
//
// usage:
//   in_* is a stream of gyro requests: tdata = {time_step, rate_z, rate_y, rate_x}
//   from the highest bit down. out_* carries the normalized attitude quaternion:
//   tdata = {quat_z, quat_y, quat_x, quat_w}, 32 bits each, highest bit first.
//   one result per request.
//   after the accepting edge the sequencer runs DELTA, PROD, NORM, SCALE, NEWT
//   (NEWTON_STEPS iterations) and OUT before out_tvalid; the single multiplier
//   forms every product in turn, including each Newton step. the scale step
//   repeats while the squared norm is far from one, and a zero norm goes
//   straight from SCALE to the output. in_tready is high only while idle, so a
//   request is taken only after the previous result's output handshake.
//   reset: attitude goes to identity (w one), previous rates to zero.
//   a stalled receiver holds out_tdata and out_tvalid; no new request is
//   taken until the result has been delivered.
module gyro_quaternion_integrator
  import gqi_pkg::*;
#(
  parameter int NEWTON_STEPS = 3
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // rate_x, rate_y, rate_z, time_step
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // quat_w, quat_x, quat_y, quat_z
);

  localparam int NW = (NEWTON_STEPS > 1) ? $clog2(NEWTON_STEPS + 1) : 1;

  gqi_state_t state_r, state_nxt;
  logic signed [31:0] att_r [4];
  logic signed [15:0] prev_r [3];
  logic signed [15:0] rate_r [3];
  logic [15:0] dt_r;
  logic signed [31:0] d_r [3];
  logic signed [33:0] p_r [4];
  logic [33:0] n2_r;
  logic [31:0] m_r;
  logic signed [5:0] k_r;
  logic [31:0] y_r;
  logic [31:0] t_r;
  logic [32:0] u_r;
  logic [4:0] cnt_r;
  logic [1:0] sub_r;
  logic [NW-1:0] it_r;
  logic signed [31:0] q_out_r [4];

  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  assign prod = ma * mb;

  // product index helpers: cnt 0..15 -> component j, term i
  logic [1:0] pj, pi;
  assign pj = cnt_r[3:2];
  assign pi = cnt_r[1:0];

  // hamilton product term table: which attitude, which d, sign; term 0 of w and term 3 of x, y, z use q directly
  logic [1:0] qsel, dsel;
  logic       neg;
  always_comb begin
    qsel = 2'd0; dsel = 2'd0; neg = 1'b0;
    case ({pj, pi})
      4'h1: begin qsel = 2'd1; dsel = 2'd0; neg = 1'b1; end
      4'h2: begin qsel = 2'd2; dsel = 2'd1; neg = 1'b1; end
      4'h3: begin qsel = 2'd3; dsel = 2'd2; neg = 1'b1; end
      4'h4: begin qsel = 2'd0; dsel = 2'd0; neg = 1'b0; end
      4'h5: begin qsel = 2'd2; dsel = 2'd2; neg = 1'b0; end
      4'h6: begin qsel = 2'd3; dsel = 2'd1; neg = 1'b1; end
      4'h7: begin qsel = 2'd1; dsel = 2'd0; neg = 1'b0; end
      4'h8: begin qsel = 2'd0; dsel = 2'd1; neg = 1'b0; end
      4'h9: begin qsel = 2'd1; dsel = 2'd2; neg = 1'b1; end
      4'ha: begin qsel = 2'd3; dsel = 2'd0; neg = 1'b0; end
      4'hb: begin qsel = 2'd2; dsel = 2'd0; neg = 1'b0; end
      4'hc: begin qsel = 2'd0; dsel = 2'd2; neg = 1'b0; end
      4'hd: begin qsel = 2'd1; dsel = 2'd1; neg = 1'b0; end
      4'he: begin qsel = 2'd2; dsel = 2'd0; neg = 1'b1; end
      4'hf: begin qsel = 2'd3; dsel = 2'd0; neg = 1'b0; end
      default: begin qsel = 2'd0; dsel = 2'd0; neg = 1'b0; end
    endcase
  end
  // direct (non-product) term of component j
  logic direct;
  assign direct = (pi == 2'd0 && pj == 2'd0) || (pi == 2'd3 && pj == 2'd3) ||
                  (pi == 2'd3 && pj == 2'd2) || (pi == 2'd3 && pj == 2'd1);

  // multiplier operand select
  always_comb begin
    ma = '0; mb = '0;
    case (state_r)
      ST_DELTA: begin
        ma = 34'(signed'({prev_r[cnt_r[1:0]][15], prev_r[cnt_r[1:0]]})
             + signed'({rate_r[cnt_r[1:0]][15], rate_r[cnt_r[1:0]]}));
        mb = signed'({18'd0, dt_r});
      end
      ST_PROD: begin
        ma = 34'(att_r[qsel]);
        mb = 34'(d_r[dsel]);
      end
      ST_NORM: begin
        ma = p_r[cnt_r[1:0]];
        mb = p_r[cnt_r[1:0]];
      end
      ST_NEWT: begin
        case (sub_r)
          2'd0: begin ma = signed'({2'b0, y_r}); mb = signed'({2'b0, y_r}); end
          2'd1: begin ma = signed'({2'b0, m_r}); mb = signed'({2'b0, t_r}); end
          default: begin
            ma = signed'({2'b0, y_r});
            mb = (u_r >= THREE_Q30) ? 34'sd0 : signed'({1'b0, THREE_Q30 - u_r});
          end
        endcase
      end
      ST_OUT: begin
        ma = p_r[cnt_r[1:0]];
        mb = signed'({2'b0, y_r});
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // rounded results of the shared product
  logic signed [67:0] rnd30;
  assign rnd30 = (prod + 68'sd536870912) >>> 30;
  logic signed [67:0] rnd2;
  assign rnd2 = (prod + 68'sd2) >>> 2;

  // output scale: round(prod / 2^(30+k)), k in [-15, 1]
  logic signed [67:0] scaled;
  logic [5:0] sh;
  assign sh = 6'(7'sd30 + 7'(k_r));
  assign scaled = (prod + (68'sd1 <<< (sh - 6'd1))) >>> sh;

  logic signed [33:0] term;
  assign term = direct ? 34'(att_r[pj]) : (neg ? -34'(rnd30) : 34'(rnd30));

  logic signed [34:0] psum;
  assign psum = 35'(p_r[pj]) + 35'(term);

  logic n2_high;
  assign n2_high = (n2_r[33:32] != 2'd0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_DELTA;
      ST_DELTA: if (cnt_r == 5'd2) state_nxt = ST_PROD;
      ST_PROD:  if (cnt_r == 5'd15) state_nxt = ST_NORM;
      ST_NORM:  if (cnt_r == 5'd3) state_nxt = ST_SCALE;
      ST_SCALE: begin
        if (n2_r == 34'd0) state_nxt = ST_DONE;
        else if (m_r != 32'd0 && m_r >= 32'h4000_0000 && !n2_high) state_nxt = ST_NEWT;
      end
      ST_NEWT:  if (sub_r == 2'd2 && it_r == NW'(NEWTON_STEPS - 1)) state_nxt = ST_OUT;
      ST_OUT:   if (cnt_r == 5'd3) state_nxt = ST_DONE;
      ST_DONE:  if (out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      att_r[0] <= 32'sd1073741824;
      att_r[1] <= '0; att_r[2] <= '0; att_r[3] <= '0;
      prev_r[0] <= '0; prev_r[1] <= '0; prev_r[2] <= '0;
      cnt_r <= '0; sub_r <= '0; it_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (in_tvalid) begin
            rate_r[0] <= in_tdata[15:0];
            rate_r[1] <= in_tdata[31:16];
            rate_r[2] <= in_tdata[47:32];
            dt_r <= in_tdata[63:48];
          end
        end
        ST_DELTA: begin
          d_r[cnt_r[1:0]] <= 32'(rnd2);
          cnt_r <= (cnt_r == 5'd2) ? 5'd0 : cnt_r + 5'd1;
          p_r[0] <= '0; p_r[1] <= '0; p_r[2] <= '0; p_r[3] <= '0;
        end
        ST_PROD: begin
          if (pi == 2'd3)
            p_r[pj] <= (psum > 35'sd2147483647) ? 34'sd2147483647 :
                       (psum < -35'sd2147483648) ? -34'sd2147483648 : 34'(psum);
          else
            p_r[pj] <= 34'(psum);
          cnt_r <= (cnt_r == 5'd15) ? 5'd0 : cnt_r + 5'd1;
          n2_r <= '0;
        end
        ST_NORM: begin
          n2_r <= n2_r + 34'(rnd30);
          cnt_r <= (cnt_r == 5'd3) ? 5'd0 : cnt_r + 5'd1;
          if (cnt_r == 5'd3) begin
            k_r <= '0;
            m_r <= 32'(n2_r + 34'(rnd30));
          end
        end
        ST_SCALE: begin
          sub_r <= '0; it_r <= '0;
          if (n2_high) begin
            n2_r <= n2_r >> 2;
            m_r <= 32'(n2_r >> 2);
            k_r <= k_r + 6'sd1;
          end else if (m_r < 32'h4000_0000) begin
            m_r <= m_r << 2;
            n2_r <= {2'b0, m_r << 2};
            k_r <= k_r - 6'sd1;
          end else begin
            y_r <= seed_lookup(4'(m_r[31:28] - 4'd4));
          end
          if (n2_r == 34'd0) begin
            q_out_r[0] <= 32'sd1073741824;
            q_out_r[1] <= '0; q_out_r[2] <= '0; q_out_r[3] <= '0;
            att_r[0] <= 32'sd1073741824;
            att_r[1] <= '0; att_r[2] <= '0; att_r[3] <= '0;
            prev_r <= rate_r;
          end
        end
        ST_NEWT: begin
          case (sub_r)
            2'd0: begin t_r <= 32'(prod >>> 30); sub_r <= 2'd1; end
            2'd1: begin u_r <= 33'(prod >>> 30); sub_r <= 2'd2; end
            default: begin
              y_r <= 32'(prod >>> 31);
              sub_r <= 2'd0;
              it_r <= it_r + NW'(1);
            end
          endcase
          cnt_r <= '0;
        end
        ST_OUT: begin
          q_out_r[cnt_r[1:0]] <= (scaled > 68'sd1073741824) ? 32'sd1073741824 :
                                 (scaled < -68'sd1073741824) ? -32'sd1073741824 :
                                 32'(scaled);
          att_r[cnt_r[1:0]] <= (scaled > 68'sd1073741824) ? 32'sd1073741824 :
                               (scaled < -68'sd1073741824) ? -32'sd1073741824 :
                               32'(scaled);
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd3) prev_r <= rate_r;
        end
        default: cnt_r <= '0;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_DONE);
  assign out_tdata  = {q_out_r[3], q_out_r[2], q_out_r[1], q_out_r[0]};

`ifndef SYNTH
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_DELTA)) else $error("no start");
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (q_out_r[0] <= 32'sd1073741824 && q_out_r[0] >= -32'sd1073741824))
    else $error("w out of range");
`endif

endmodule
